[hw/rtl/wcn_pkg.sv]
// shared constants, types and helpers of the worley cell noise pipeline
package wcn_pkg;

    localparam int POS_W      = 26;
    localparam int POSY_W     = 7;
    localparam int CELL_WIDTH = 16;
    localparam int CELL_SHIFT = 4;
    localparam int BASE_W     = POS_W - CELL_SHIFT;
    localparam int CX_W       = BASE_W + 1;
    localparam int NOISE_W    = 17;
    localparam int DIST_W     = 20;
    localparam int THR_W      = 20;
    localparam int SCALE_W    = 16;
    localparam int SEED_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [31:0] PRIME_A = 32'h85297A4D;
    localparam logic [31:0] PRIME_B = 32'h68E31DA4;
    localparam logic [31:0] PRIME_C = 32'hB5297A4D;
    localparam logic [31:0] PRIME_D = 32'h45D9F3B3;

    localparam logic [DIST_W-1:0]  DIST_MAX  = 20'hFFFFF;
    localparam logic [THR_W-1:0]   THR_RST   = 20'd4096;
    localparam logic [SCALE_W-1:0] SCALE_ONE = 16'd4096;

    // pipeline depths of the sub-blocks
    localparam int COL_STAGES    = 4;
    localparam int LANE_STAGES   = 15;
    localparam int MIN_STAGES    = 2;
    localparam int DIV_STAGES    = 16;
    localparam int SMOOTH_STAGES = DIV_STAGES + 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HASH_SEED = 3'd0,
        CFG_FALLOFF   = 3'd1,
        CFG_SCALE_X   = 3'd2,
        CFG_SCALE_Y   = 3'd3,
        CFG_SCALE_Z   = 3'd4
    } t_cfg_idx;

    // per-position data that rides along the cell lanes
    typedef struct packed {
        logic [POSY_W-1:0] py;
        logic [3:0]        px4;
        logic [3:0]        pz4;
        logic [3:0]        bx4;
        logic [3:0]        bz4;
    } t_side;

    // low 32 bits of (h << k) | (h >>> (32 - k)); only bits up to 63-k of h matter
    function automatic logic [31:0] rot32(input logic [63:0] h, input int unsigned k);
        logic [63:0] v;
        v = (h << k) | (h >> (32 - k));
        return v[31:0];
    endfunction

endpackage

[hw/rtl/worley_cell_noise.sv]
// worley cell noise top level: config registers, cell fan-out, minimum and pipeline control
//
// One block position in per transaction on the input channel (i_in_valid /
// o_in_stall), one result out per transaction on the output channel
// (o_out_valid / i_out_stall): 1 - smoothstep of the nearest distance in Q1.16
// and the nearest feature point distance in Q12.8.
// Configuration is a write port (i_cfg_wr_en, i_cfg_index, i_cfg_data); write it
// only while no position is in flight.
// Throughput: one position per cycle while the receiver does not stall. The
// depth is set by the nine hash lanes with their split 64-bit multiplies, a
// bit-per-stage square root and a bit-per-stage divider.
// The pipeline moves as one: it halts only while a result is held at the
// output and the receiver stalls, so o_in_stall is high exactly then; nothing
// is lost or repeated. Synchronous reset clears the valid bits and loads the
// register defaults (seed 0, threshold and scales 4096).
module worley_cell_noise #(
    parameter int CELL_HEIGHT = 128
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [wcn_pkg::POS_W-1:0]     i_pos_x,
    input  logic [wcn_pkg::POSY_W-1:0]           i_pos_y,
    input  logic signed [wcn_pkg::POS_W-1:0]     i_pos_z,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [wcn_pkg::NOISE_W-1:0]          o_noise_value,
    output logic [wcn_pkg::DIST_W-1:0]           o_nearest_distance,
    input  logic                                 i_cfg_wr_en,
    input  logic [wcn_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [wcn_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import wcn_pkg::*;

    localparam int HB   = $clog2(CELL_HEIGHT);
    localparam int YW   = HB + 6;
    localparam int D2W  = 2 * YW + 2;
    localparam int SQW  = D2W + 16;
    localparam int RW   = (SQW + 1) / 2;
    localparam int CMPW = (RW > DIST_W) ? RW : DIST_W;
    localparam int LAT  = 1 + COL_STAGES + LANE_STAGES + MIN_STAGES + RW + SMOOTH_STAGES;

    logic [SEED_W-1:0]  r_seed;
    logic [THR_W-1:0]   r_falloff;
    logic [SCALE_W-1:0] r_scale_x;
    logic [SCALE_W-1:0] r_scale_y;
    logic [SCALE_W-1:0] r_scale_z;

    logic [LAT-1:0]     r_vld;
    logic               w_en;

    logic signed [POS_W-1:0] r_pos_x;
    logic [POSY_W-1:0]       r_pos_y;
    logic signed [POS_W-1:0] r_pos_z;

    logic signed [BASE_W-1:0] w_base_x;
    logic signed [BASE_W-1:0] w_base_z;
    logic signed [CX_W-1:0]   w_cx [0:2];
    logic signed [CX_W-1:0]   w_cz [0:2];
    logic signed [55:0]       w_zp [0:2];
    logic [46:0]              w_prod4 [0:2];
    logic [52:0]              r_zp [0:3][0:2];
    t_side                    w_side;
    t_side                    r_side [0:3];

    logic [D2W-1:0] w_d2 [0:8];
    logic [D2W-1:0] r_min3 [0:2];
    logic [D2W-1:0] r_best;
    logic [D2W-1:0] w_m3 [0:2];
    logic [D2W-1:0] w_m01;

    logic [RW-1:0]     w_root;
    logic [CMPW-1:0]   w_root_ext;
    logic [DIST_W-1:0] w_dist;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed    <= '0;
            r_falloff <= THR_RST;
            r_scale_x <= SCALE_ONE;
            r_scale_y <= SCALE_ONE;
            r_scale_z <= SCALE_ONE;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_HASH_SEED: r_seed    <= i_cfg_data;
                CFG_FALLOFF:   r_falloff <= i_cfg_data[THR_W-1:0];
                CFG_SCALE_X:   r_scale_x <= i_cfg_data[SCALE_W-1:0];
                CFG_SCALE_Y:   r_scale_y <= i_cfg_data[SCALE_W-1:0];
                CFG_SCALE_Z:   r_scale_z <= i_cfg_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // whole pipeline advances unless a result sits stalled at the output
    assign w_en        = !(r_vld[LAT-1] && i_out_stall);
    assign o_in_stall  = !w_en;
    assign o_out_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pos_x <= i_pos_x;
            r_pos_y <= i_pos_y;
            r_pos_z <= i_pos_z;
        end
    end

    // floor division by the cell width is an arithmetic shift
    assign w_base_x = r_pos_x[POS_W-1:CELL_SHIFT];
    assign w_base_z = r_pos_z[POS_W-1:CELL_SHIFT];

    assign w_side.py  = r_pos_y;
    assign w_side.px4 = r_pos_x[CELL_SHIFT-1:0];
    assign w_side.pz4 = r_pos_z[CELL_SHIFT-1:0];
    assign w_side.bx4 = w_base_x[3:0];
    assign w_side.bz4 = w_base_z[3:0];

    for (genvar gi = 0; gi < 3; gi++) begin : g_col
        assign w_cx[gi] = {w_base_x[BASE_W-1], w_base_x} + CX_W'(gi - 1);
        assign w_cz[gi] = {w_base_z[BASE_W-1], w_base_z} + CX_W'(gi - 1);
        assign w_zp[gi] = $signed(w_cz[gi]) * $signed({1'b0, PRIME_C});

        wcn_col_hash u_col (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_cx   (w_cx[gi]),
            .i_seed (r_seed),
            .o_prod (w_prod4[gi])
        );
    end

    // z products and side data wait for the column hash
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= w_side;
            for (int s = 1; s < COL_STAGES; s++) begin
                r_side[s] <= r_side[s-1];
            end
            for (int j = 0; j < 3; j++) begin
                r_zp[0][j] <= w_zp[j][52:0];
                for (int s = 1; s < COL_STAGES; s++) begin
                    r_zp[s][j] <= r_zp[s-1][j];
                end
            end
        end
    end

    for (genvar gi = 0; gi < 3; gi++) begin : g_lx
        for (genvar gj = 0; gj < 3; gj++) begin : g_lz
            wcn_cell_lane #(
                .CELL_HEIGHT (CELL_HEIGHT),
                .DX_OFF      (gi - 1),
                .DZ_OFF      (gj - 1)
            ) u_lane (
                .i_clk     (i_clk),
                .i_en      (w_en),
                .i_prod    (w_prod4[gi]),
                .i_zp      (r_zp[COL_STAGES-1][gj]),
                .i_side    (r_side[COL_STAGES-1]),
                .i_scale_x (r_scale_x),
                .i_scale_y (r_scale_y),
                .i_scale_z (r_scale_z),
                .o_d2      (w_d2[gi*3+gj])
            );
        end
    end

    // two-level minimum over the nine cells
    for (genvar gk = 0; gk < 3; gk++) begin : g_min
        logic [D2W-1:0] w_a;
        assign w_a       = (w_d2[3*gk] < w_d2[3*gk+1]) ? w_d2[3*gk] : w_d2[3*gk+1];
        assign w_m3[gk]  = (w_a < w_d2[3*gk+2]) ? w_a : w_d2[3*gk+2];
    end

    assign w_m01 = (r_min3[0] < r_min3[1]) ? r_min3[0] : r_min3[1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_min3[k] <= w_m3[k];
            end
            r_best <= (w_m01 < r_min3[2]) ? w_m01 : r_min3[2];
        end
    end

    wcn_isqrt #(
        .IN_W (SQW)
    ) u_isqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_val  ({r_best, 16'b0}),
        .o_root (w_root)
    );

    assign w_root_ext = CMPW'(w_root);
    assign w_dist     = (w_root_ext > CMPW'(DIST_MAX)) ? DIST_MAX : DIST_W'(w_root);

    wcn_smooth u_smooth (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_dist  (w_dist),
        .i_thr   (r_falloff),
        .o_noise (o_noise_value),
        .o_dist  (o_nearest_distance)
    );

    // input side only halts behind a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a stalled result");

    a_noise_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_noise_value <= 17'd65536))
        else $error("noise above one");

    a_beyond_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_nearest_distance >= r_falloff)) |-> (o_noise_value == '0))
        else $error("noise not zero beyond falloff edge");

    a_on_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_nearest_distance == '0) && (r_falloff != '0))
        |-> (o_noise_value == 17'd65536))
        else $error("noise not one on a feature point");

endmodule

[hw/rtl/wcn_col_hash.sv]
// first part of the coordinate hash, shared by the three cells of one column
module wcn_col_hash (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic signed [wcn_pkg::CX_W-1:0] i_cx,
    input  logic [wcn_pkg::SEED_W-1:0] i_seed,
    output logic [46:0]               o_prod
);
    import wcn_pkg::*;

    logic signed [55:0] w_p;
    logic [50:0]        r_x;
    logic [63:0]        w_mlo;
    logic [50:0]        w_mhi;
    logic [63:0]        r_mlo;
    logic [18:0]        r_mhi;
    logic [50:0]        w_s;
    logic [31:0]        r_h;
    logic [63:0]        w_prod;
    logic [46:0]        r_prod;

    assign w_p    = $signed(i_cx) * $signed({1'b0, PRIME_A});
    assign w_mlo  = r_x[31:0] * PRIME_A;
    assign w_mhi  = r_x[50:32] * PRIME_A;
    assign w_s    = r_mlo[50:0] + {r_mhi, 32'b0};
    assign w_prod = r_h * PRIME_A;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= {w_p[50:32], w_p[31:0] ^ i_seed};
            r_mlo  <= w_mlo;
            r_mhi  <= w_mhi[18:0];
            r_h    <= rot32(64'(w_s), 13);
            r_prod <= w_prod[46:0];
        end
    end

    assign o_prod = r_prod;

endmodule

[hw/rtl/wcn_cell_lane.sv]
// per-cell hash tail, feature point placement and squared distance
module wcn_cell_lane #(
    parameter int CELL_HEIGHT = 128,
    parameter int DX_OFF      = 0,
    parameter int DZ_OFF      = 0,
    localparam int HB  = $clog2(CELL_HEIGHT),
    localparam int YW  = HB + 6,
    localparam int D2W = 2 * YW + 2
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [46:0]                  i_prod,
    input  logic [52:0]                  i_zp,
    input  wcn_pkg::t_side               i_side,
    input  logic [wcn_pkg::SCALE_W-1:0]  i_scale_x,
    input  logic [wcn_pkg::SCALE_W-1:0]  i_scale_y,
    input  logic [wcn_pkg::SCALE_W-1:0]  i_scale_z,
    output logic [D2W-1:0]               o_d2
);
    import wcn_pkg::*;

    localparam int          HI_MOD = 65536 % CELL_HEIGHT;
    localparam logic [7:0]  HI_MOD_V = 8'(HI_MOD);
    localparam logic [28:0] MREC = 29'((64'd1 << 32) / CELL_HEIGHT);
    localparam logic [8:0]  CH_V = 9'(CELL_HEIGHT);
    localparam logic [HB:0] CH_CMP = (HB + 1)'(CELL_HEIGHT);
    localparam logic signed [10:0] XOFF = 11'(DX_OFF * CELL_WIDTH);
    localparam logic signed [10:0] ZOFF = 11'(DZ_OFF * CELL_WIDTH);

    // side data, index = lane stage
    t_side r_sd [1:13];
    logic [7:0] r_lx [10:13];
    logic [7:0] r_lz [10:13];

    logic [52:0] r_x1;
    logic [63:0] r_mlo2;
    logic [20:0] r_mhi2;
    logic [31:0] r_h3;
    logic [63:0] r_g4;
    logic [63:0] r_mlo5;
    logic [9:0]  r_mhi5;
    logic [41:0] r_k6;
    logic [63:0] r_mlo7;
    logic [9:0]  r_mhi7;
    logic [30:0] r_q8;
    logic [30:0] r_r9;
    logic [23:0] r_v10;
    logic [23:0] r_v11;
    logic [20:0] r_qt11;
    logic [HB-1:0]   r_rem12;
    logic [HB+3:0]   r_ly13;
    logic [21:0]     r_sqx14;
    logic [2*YW-1:0] r_sqy14;
    logic [21:0]     r_sqz14;
    logic [D2W-1:0]  r_d2;

    logic [31:0] w_h2;
    logic [63:0] w_mlo2;
    logic [52:0] w_mhi2;
    logic [52:0] w_s3;
    logic [63:0] w_g4;
    logic [41:0] w_y5;
    logic [63:0] w_mlo5;
    logic [41:0] w_mhi5;
    logic [63:0] w_mlo7;
    logic [41:0] w_mhi7;
    logic [41:0] w_n8;
    logic [62:0] w_r9;
    logic [3:0]  w_cx4;
    logic [3:0]  w_cz4;
    logic [19:0] w_lxp;
    logic [19:0] w_lzp;
    logic [22:0] w_hm;
    logic [52:0] w_qp;
    logic [29:0] w_qc;
    logic [23:0] w_t12;
    logic [HB:0] w_rem0;
    logic [HB-1:0] w_rem;
    logic [HB+15:0] w_lyp;
    logic signed [10:0]   w_dx;
    logic signed [10:0]   w_dz;
    logic signed [YW-1:0] w_dy;
    logic signed [21:0]   w_sqx;
    logic signed [21:0]   w_sqz;
    logic signed [2*YW-1:0] w_sqy;

    // hash tail
    assign w_h2   = rot32(64'(i_prod), 17);
    assign w_mlo2 = r_x1[31:0] * PRIME_A;
    assign w_mhi2 = r_x1[52:32] * PRIME_A;
    assign w_s3   = r_mlo2[52:0] + {r_mhi2, 32'b0};
    assign w_g4   = (r_h3 ^ (r_h3 >> 16)) * PRIME_A;
    assign w_y5   = r_g4[41:0] ^ r_g4[49:8];
    assign w_mlo5 = w_y5[31:0] * PRIME_A;
    assign w_mhi5 = w_y5[41:32] * PRIME_A;
    assign w_mlo7 = r_k6[31:0] * PRIME_D;
    assign w_mhi7 = r_k6[41:32] * PRIME_D;
    assign w_n8   = r_mlo7[41:0] + {r_mhi7, 32'b0};
    assign w_r9   = r_q8 * PRIME_A;

    // feature offsets; floor-mod by the cell width is the low nibble
    assign w_cx4 = r_sd[9].bx4 + 4'(DX_OFF);
    assign w_cz4 = r_sd[9].bz4 + 4'(DZ_OFF);
    assign w_lxp = (r_r9[3:0] ^ w_cx4) * i_scale_x;
    assign w_lzp = (r_r9[3:0] ^ w_cz4) * i_scale_z;

    // hash mod cell height: fold the top half, then reciprocal multiply
    assign w_hm   = r_r9[30:16] * HI_MOD_V;
    assign w_qp   = r_v10 * MREC;
    assign w_qc   = r_qt11 * CH_V;
    assign w_t12  = r_v11 - w_qc[23:0];
    assign w_rem0 = w_t12[HB:0];
    assign w_rem  = (w_rem0 >= CH_CMP) ? HB'(w_rem0 - CH_CMP) : HB'(w_rem0);
    assign w_lyp  = r_rem12 * i_scale_y;

    assign w_dx  = $signed({7'b0, r_sd[13].px4}) - $signed({3'b0, r_lx[13]}) - XOFF;
    assign w_dz  = $signed({7'b0, r_sd[13].pz4}) - $signed({3'b0, r_lz[13]}) - ZOFF;
    assign w_dy  = $signed(YW'(r_sd[13].py)) - $signed(YW'(r_ly13));
    assign w_sqx = w_dx * w_dx;
    assign w_sqz = w_dz * w_dz;
    assign w_sqy = w_dy * w_dy;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sd[1] <= i_side;
            for (int s = 2; s <= 13; s++) begin
                r_sd[s] <= r_sd[s-1];
            end
            r_x1   <= {i_zp[52:32], i_zp[31:0] ^ w_h2};
            r_mlo2 <= w_mlo2;
            r_mhi2 <= w_mhi2[20:0];
            r_h3   <= rot32(64'(w_s3), 11);
            r_g4   <= w_g4;
            r_mlo5 <= w_mlo5;
            r_mhi5 <= w_mhi5[9:0];
            r_k6   <= r_mlo5[41:0] + {r_mhi5, 32'b0};
            r_mlo7 <= w_mlo7;
            r_mhi7 <= w_mhi7[9:0];
            r_q8   <= w_n8[30:0] ^ w_n8[41:11];
            r_r9   <= w_r9[30:0];
            r_v10  <= 24'(w_hm) + 24'(r_r9[15:0]);
            r_lx[10] <= w_lxp[19:12];
            r_lz[10] <= w_lzp[19:12];
            for (int s = 11; s <= 13; s++) begin
                r_lx[s] <= r_lx[s-1];
                r_lz[s] <= r_lz[s-1];
            end
            r_qt11  <= w_qp[52:32];
            r_v11   <= r_v10;
            r_rem12 <= w_rem;
            r_ly13  <= w_lyp[HB+15:12];
            r_sqx14 <= w_sqx;
            r_sqz14 <= w_sqz;
            r_sqy14 <= w_sqy;
            r_d2    <= D2W'(r_sqx14) + D2W'(r_sqy14) + D2W'(r_sqz14);
        end
    end

    assign o_d2 = r_d2;

endmodule

[hw/rtl/wcn_isqrt.sv]
// pipelined integer square root, one result bit per stage
module wcn_isqrt #(
    parameter int IN_W = 44,
    localparam int RW = (IN_W + 1) / 2
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [IN_W-1:0] i_val,
    output logic [RW-1:0]   o_root
);
    import wcn_pkg::*;

    localparam int TW = 2 * RW + 1;

    logic [TW-1:0] r_rem [0:RW-1];
    logic [RW-1:0] r_res [0:RW-1];

    for (genvar gs = 0; gs < RW; gs++) begin : g_stage
        localparam int B = RW - 1 - gs;
        logic [TW-1:0] w_rem_in;
        logic [RW-1:0] w_res_in;
        logic [TW-1:0] w_trial;

        if (gs == 0) begin : g_first
            assign w_rem_in = TW'(i_val);
            assign w_res_in = '0;
        end else begin : g_next
            assign w_rem_in = r_rem[gs-1];
            assign w_res_in = r_res[gs-1];
        end

        // (res + 2^B)^2 - res^2
        assign w_trial = (TW'(w_res_in) << (B + 1)) + (TW'(1) << (2 * B));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_rem_in >= w_trial) begin
                    r_rem[gs] <= w_rem_in - w_trial;
                    r_res[gs] <= w_res_in | (RW'(1) << B);
                end else begin
                    r_rem[gs] <= w_rem_in;
                    r_res[gs] <= w_res_in;
                end
            end
        end
    end

    assign o_root = r_res[RW-1];

endmodule

[hw/rtl/wcn_smooth.sv]
// falloff: restoring divide to Q0.16, then (1-t)^2 (1+2t)
module wcn_smooth (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [wcn_pkg::DIST_W-1:0]  i_dist,
    input  logic [wcn_pkg::THR_W-1:0]   i_thr,
    output logic [wcn_pkg::NOISE_W-1:0] o_noise,
    output logic [wcn_pkg::DIST_W-1:0]  o_dist
);
    import wcn_pkg::*;

    localparam int LAST = SMOOTH_STAGES - 1;

    logic [DIST_W-1:0] r_dist [0:LAST];
    logic              r_ge   [0:LAST-1];
    logic [THR_W:0]    r_rem  [0:DIV_STAGES];
    logic [15:0]       r_q    [1:DIV_STAGES];
    logic [33:0]       r_uu;
    logic [17:0]       r_w;
    logic [NOISE_W-1:0] r_noise;

    logic        w_ge;
    logic [16:0] w_u;
    logic [51:0] w_prod;

    assign w_ge = i_dist >= i_thr;

    for (genvar gs = 1; gs <= DIV_STAGES; gs++) begin : g_div
        logic [THR_W:0] w_sh;
        logic           w_take;
        assign w_sh   = {r_rem[gs-1][THR_W-1:0], 1'b0};
        assign w_take = w_sh >= {1'b0, i_thr};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[gs] <= w_take ? (w_sh - {1'b0, i_thr}) : w_sh;
            end
        end

        if (gs == 1) begin : g_head
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_q[gs] <= {15'b0, w_take};
                end
            end
        end else begin : g_tail
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_q[gs] <= {r_q[gs-1][14:0], w_take};
                end
            end
        end
    end

    assign w_u    = 17'd65536 - {1'b0, r_q[DIV_STAGES]};
    assign w_prod = r_uu * r_w;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dist[0] <= i_dist;
            r_ge[0]   <= w_ge;
            r_rem[0]  <= w_ge ? '0 : {1'b0, i_dist};
            for (int s = 1; s <= LAST; s++) begin
                r_dist[s] <= r_dist[s-1];
            end
            for (int s = 1; s <= LAST - 1; s++) begin
                r_ge[s] <= r_ge[s-1];
            end
            r_uu    <= w_u * w_u;
            r_w     <= 18'd65536 + {1'b0, r_q[DIV_STAGES], 1'b0};
            r_noise <= r_ge[LAST-1] ? '0 : w_prod[48:32];
        end
    end

    assign o_noise = r_noise;
    assign o_dist  = r_dist[LAST];

endmodule
